FILE: rtl/rme_pkg.sv
`default_nettype none
package rme_pkg;
    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3, OP_CMP = 4'd4,
        OP_MOV = 4'd5, OP_JMP = 4'd6, OP_LDC = 4'd7, OP_INP = 4'd8, OP_PRT = 4'd9,
        OP_HLT = 4'd10
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_DIV_ZERO = 2'd1, ST_BAD_OP = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EXEC, S_ITER, S_WB2, S_OUT
    } t_state;

    localparam logic [5:0] COND_ALWAYS = 6'd0;
    localparam logic [5:0] COND_ZERO   = 6'd1;
    localparam logic [5:0] COND_NZERO  = 6'd2;
    localparam logic [5:0] COND_POS    = 6'd3;
    localparam logic [5:0] COND_NEG    = 6'd4;
    localparam logic [5:0] COND_PZ     = 6'd5;
    localparam logic [5:0] COND_NZ     = 6'd6;

    typedef struct packed {
        logic [15:0] instr_word;
        logic [31:0] immediate;
        logic [31:0] console_value;
    } t_in;

    typedef struct packed {
        logic [15:0] next_pc;
        logic        print_valid;
        logic [31:0] print_value;
        logic        halted;
        logic [1:0]  status;
    } t_out;

    // Control between the sequencer and the shared multiply/divide unit.
    typedef struct packed {
        logic start;
        logic is_div;
    } t_md_ctl;
endpackage
`default_nettype wire

FILE: rtl/rme_if.sv
`default_nettype none
interface rme_in_if;
    logic        valid;
    logic        ready;
    rme_pkg::t_in payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface rme_out_if;
    logic         valid;
    logic         ready;
    rme_pkg::t_out payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: rtl/rme_muldiv.sv
`default_nettype none
// Shared iterative unit: shift-add multiply or restoring signed divide,
// one bit per cycle over 32 iterations; o_done is high for one cycle
// right after the last iteration.
module rme_muldiv (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire rme_pkg::t_md_ctl i_ctl,
    input  wire logic [31:0]     i_a,
    input  wire logic [31:0]     i_b,
    output logic                 o_done,
    output logic [31:0]          o_lo,
    output logic [31:0]          o_hi
);
    logic        r_busy, n_busy;
    logic        r_div;
    logic [5:0]  r_cnt;
    logic [31:0] r_acc, r_q, r_d;
    logic        r_qneg, r_rneg;
    logic [32:0] w_trial;
    logic [31:0] w_rem_sh;

    assign w_rem_sh = {r_acc[30:0], r_q[31]};
    assign w_trial = {1'b0, w_rem_sh} - {1'b0, r_d};
    assign n_busy = i_ctl.start ? 1'b1 : (r_busy && r_cnt != 6'd31);

    // Iteration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            o_done <= r_busy && r_cnt == 6'd31;
            r_cnt  <= i_ctl.start ? 6'd0 : r_cnt + 6'd1;
        end
        if (i_ctl.start) begin
            r_div  <= i_ctl.is_div;
            r_acc  <= '0;
            r_qneg <= i_a[31] ^ i_b[31];
            r_rneg <= i_a[31];
            if (i_ctl.is_div) begin
                r_q <= i_a[31] ? 32'd0 - i_a : i_a;
                r_d <= i_b[31] ? 32'd0 - i_b : i_b;
            end else begin
                r_q <= i_a;
                r_d <= i_b;
            end
        end else if (r_busy) begin
            if (r_div) begin
                if (!w_trial[32]) begin
                    r_acc <= w_trial[31:0];
                    r_q   <= {r_q[30:0], 1'b1};
                end else begin
                    r_acc <= w_rem_sh;
                    r_q   <= {r_q[30:0], 1'b0};
                end
            end else begin
                r_acc <= (r_q[31] ? r_d : 32'd0) + {r_acc[30:0], 1'b0};
                r_q   <= {r_q[30:0], 1'b0};
            end
        end
    end

    // Sign fixup; multiply product low word sits in the accumulator.
    always_comb begin
        if (r_div) begin
            o_lo = r_qneg ? 32'd0 - r_q : r_q;
            o_hi = r_rneg ? 32'd0 - r_acc : r_acc;
        end else begin
            o_lo = r_acc;
            o_hi = '0;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/register_machine_execute_top.sv
`default_nettype none
// Executes one register-machine instruction per input transfer and returns one
// result transfer. After the input transfer, simple instructions pass through
// register read, execute with write back and output; a new instruction is
// accepted only after the result transfer, back in the idle state. Multiply and
// divide use a shared one-bit-per-cycle unit of 32 iterations, and divide also
// writes the remainder. The 64-entry register file is a single-write memory
// with a two-port registered read; a reset clears it with a sweep over all
// entries during which no input is accepted.
module register_machine_execute_top #(
    parameter int REG_COUNT = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rme_in_if.sink    i_in,
    rme_out_if.source o_out
);
    localparam int IW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    rme_pkg::t_state r_state, n_state;
    logic [31:0] r_mem [REG_COUNT];
    logic [31:0] r_a, r_b;
    rme_pkg::t_in r_item;
    rme_pkg::t_out r_res;
    logic r_z, r_p, r_n;
    logic [15:0] r_jc, r_pc;
    logic r_clr;
    logic [IW:0] r_clr_idx;
    logic [31:0] r_q2;

    logic [3:0]  w_op;
    logic [5:0]  w_r1, w_r2;
    logic        w_v1, w_v2;
    logic        w_we;
    logic [5:0]  w_wa;
    logic [31:0] w_wd;
    logic [31:0] w_val;
    logic        w_setf, w_cond;
    rme_pkg::t_md_ctl w_md;
    logic        w_md_done;
    logic [31:0] w_lo, w_hi;

    assign w_op = r_item.instr_word[3:0];
    assign w_r1 = r_item.instr_word[9:4];
    assign w_r2 = r_item.instr_word[15:10];
    assign w_v1 = {26'd0, w_r1} < 32'(REG_COUNT);
    assign w_v2 = {26'd0, w_r2} < 32'(REG_COUNT);

    rme_muldiv u_md (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_md),
        .i_a(r_a), .i_b(r_b), .o_done(w_md_done), .o_lo(w_lo), .o_hi(w_hi)
    );

    assign i_in.ready  = (r_state == rme_pkg::S_IDLE) && !r_clr;
    assign o_out.valid = (r_state == rme_pkg::S_OUT);
    assign o_out.payload = r_res;

    // Jump condition from the flags.
    always_comb begin
        case (w_r1)
            rme_pkg::COND_ALWAYS: w_cond = 1'b1;
            rme_pkg::COND_ZERO:   w_cond = r_z;
            rme_pkg::COND_NZERO:  w_cond = !r_z;
            rme_pkg::COND_POS:    w_cond = r_p;
            rme_pkg::COND_NEG:    w_cond = r_n;
            rme_pkg::COND_PZ:     w_cond = r_p || r_z;
            rme_pkg::COND_NZ:     w_cond = r_n || r_z;
            default:              w_cond = 1'b0;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rme_pkg::S_IDLE: if (i_in.valid && i_in.ready) n_state = rme_pkg::S_READ;
            rme_pkg::S_READ: n_state = rme_pkg::S_EXEC;
            rme_pkg::S_EXEC: begin
                if ((w_op == rme_pkg::OP_MUL) ||
                    (w_op == rme_pkg::OP_DIV && r_b != 32'd0)) begin
                    n_state = rme_pkg::S_ITER;
                end else begin
                    n_state = rme_pkg::S_OUT;
                end
            end
            rme_pkg::S_ITER: begin
                if (w_md_done) begin
                    n_state = (w_op == rme_pkg::OP_DIV) ? rme_pkg::S_WB2 : rme_pkg::S_OUT;
                end
            end
            rme_pkg::S_WB2: n_state = rme_pkg::S_OUT;
            rme_pkg::S_OUT: if (o_out.ready) n_state = rme_pkg::S_IDLE;
            default: n_state = rme_pkg::S_IDLE;
        endcase
    end

    // Datapath control outputs: register write, flag update, unit start.
    always_comb begin
        w_we   = 1'b0;
        w_wa   = w_r1;
        w_wd   = '0;
        w_val  = '0;
        w_setf = 1'b0;
        w_md.start  = (r_state == rme_pkg::S_EXEC) && (n_state == rme_pkg::S_ITER);
        w_md.is_div = (w_op == rme_pkg::OP_DIV);
        case (r_state)
            rme_pkg::S_EXEC: begin
                case (w_op)
                    rme_pkg::OP_ADD: begin w_val = r_a + r_b; w_we = 1'b1; w_setf = 1'b1; end
                    rme_pkg::OP_SUB: begin w_val = r_a - r_b; w_we = 1'b1; w_setf = 1'b1; end
                    rme_pkg::OP_CMP: begin w_val = r_a - r_b; w_setf = 1'b1; end
                    rme_pkg::OP_MOV: begin w_val = r_b; w_we = 1'b1; end
                    rme_pkg::OP_LDC: begin w_val = r_item.immediate; w_we = 1'b1; end
                    rme_pkg::OP_INP: begin w_val = r_item.console_value; w_we = 1'b1; end
                    default: w_val = '0;
                endcase
                w_wd = w_val;
                w_we = w_we && w_v1;
                if (w_setf && !w_v1 && w_op != rme_pkg::OP_CMP) w_val = '0;
            end
            rme_pkg::S_ITER: begin
                if (w_md_done) begin
                    w_wd = w_lo;
                    w_we = w_v1;
                end
            end
            rme_pkg::S_WB2: begin
                w_wa = w_r2;
                w_wd = r_q2;
                w_we = w_v2;
                w_setf = 1'b1;
                // Flags follow R1 after both writes.
                if (!w_v1) w_val = '0;
                else if (w_r1 == w_r2) w_val = r_q2;
                else w_val = w_lo;
            end
            default: w_we = 1'b0;
        endcase
        if (r_state == rme_pkg::S_ITER && w_md_done && w_op == rme_pkg::OP_MUL) begin
            w_setf = 1'b1;
            w_val  = w_v1 ? w_lo : 32'd0;
        end
    end

    // Register file: clearing sweep, single write, registered two-port read.
    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            r_mem[r_clr_idx[IW-1:0]] <= '0;
        end else if (w_we) begin
            r_mem[w_wa[IW-1:0]] <= w_wd;
        end
        if (r_state == rme_pkg::S_READ) begin
            r_a <= w_v1 ? r_mem[w_r1[IW-1:0]] : 32'd0;
            r_b <= w_v2 ? r_mem[w_r2[IW-1:0]] : 32'd0;
        end
    end

    // Sequencer, flags, counters and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rme_pkg::S_IDLE;
            r_z <= 1'b0; r_p <= 1'b0; r_n <= 1'b0;
            r_jc <= '0; r_pc <= '0;
            r_clr     <= 1'b1;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (r_clr) begin
                r_clr_idx <= r_clr_idx + (IW+1)'(1);
                if (r_clr_idx == (IW+1)'(REG_COUNT - 1)) r_clr <= 1'b0;
            end
            if (w_setf) begin
                r_z <= (w_val == 32'd0);
                r_n <= w_val[31];
                r_p <= (w_val != 32'd0) && !w_val[31];
            end
            if (r_state == rme_pkg::S_EXEC) begin
                if (w_op == rme_pkg::OP_LDC) r_jc <= r_jc + 16'd1;
                if (w_op == rme_pkg::OP_JMP && w_cond) begin
                    r_jc <= r_item.immediate[31] ? 16'd0 : r_jc + 16'd1;
                end
            end
            if (r_state == rme_pkg::S_OUT && o_out.ready) r_pc <= r_res.next_pc;
        end
        if (i_in.valid && i_in.ready) r_item <= i_in.payload;
        if (w_md_done) r_q2 <= w_hi;
        if (r_state == rme_pkg::S_EXEC) begin
            r_res.print_valid <= 1'b0;
            r_res.print_value <= '0;
            r_res.halted      <= 1'b0;
            r_res.status      <= rme_pkg::ST_OK;
            r_res.next_pc     <= r_pc + 16'd1;
            case (w_op)
                rme_pkg::OP_ADD, rme_pkg::OP_SUB, rme_pkg::OP_MUL, rme_pkg::OP_CMP,
                rme_pkg::OP_MOV, rme_pkg::OP_INP: r_res.next_pc <= r_pc + 16'd1;
                rme_pkg::OP_DIV: begin
                    if (r_b == 32'd0) begin
                        r_res.next_pc <= r_pc;
                        r_res.halted  <= 1'b1;
                        r_res.status  <= rme_pkg::ST_DIV_ZERO;
                    end
                end
                rme_pkg::OP_JMP: begin
                    if (!w_cond) r_res.next_pc <= r_pc + 16'd3;
                    else if (!r_item.immediate[31])
                        r_res.next_pc <= r_pc + r_item.immediate[15:0] + 16'd2;
                    else
                        r_res.next_pc <= r_pc + r_item.immediate[15:0] - {r_jc[14:0], 1'b0};
                end
                rme_pkg::OP_LDC: r_res.next_pc <= r_pc + 16'd3;
                rme_pkg::OP_PRT: begin
                    r_res.print_valid <= 1'b1;
                    r_res.print_value <= r_a;
                end
                rme_pkg::OP_HLT: begin
                    r_res.next_pc <= 16'hFFFF;
                    r_res.halted  <= 1'b1;
                end
                default: begin
                    r_res.next_pc <= r_pc;
                    r_res.halted  <= 1'b1;
                    r_res.status  <= rme_pkg::ST_BAD_OP;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: bench/rme_exec_checker.sv
`timescale 1ns / 100ps
`default_nettype none
// Watches both channels of the execute block, predicts every result from the
// accepted instructions and compares the results in order.
module rme_exec_checker (
    input  wire logic i_clk,
    rme_in_if         i_mon_in,
    rme_out_if        i_mon_out,
    output int        o_err_count,
    output int        o_pending
);
    // Architectural state of the machine as seen by the predictor.
    logic [31:0] arch_regs [64];
    logic        flag_zero;
    logic        flag_pos;
    logic        flag_neg;
    logic [15:0] jump_ldc_count;
    logic [15:0] prog_counter;

    rme_pkg::t_out expected_results[$];

    initial begin
        for (int i = 0; i < 64; i++) arch_regs[i] = '0;
        flag_zero      = 1'b0;
        flag_pos       = 1'b0;
        flag_neg       = 1'b0;
        jump_ldc_count = '0;
        prog_counter   = '0;
        o_err_count    = 0;
        o_pending      = 0;
    end

    function automatic void update_flags(input logic [31:0] value);
        flag_zero = (value == 32'd0);
        flag_neg  = value[31];
        flag_pos  = !flag_zero && !flag_neg;
    endfunction

    function automatic logic cond_true(input logic [5:0] cond);
        case (cond)
            rme_pkg::COND_ALWAYS: return 1'b1;
            rme_pkg::COND_ZERO:   return flag_zero;
            rme_pkg::COND_NZERO:  return !flag_zero;
            rme_pkg::COND_POS:    return flag_pos;
            rme_pkg::COND_NEG:    return flag_neg;
            rme_pkg::COND_PZ:     return flag_pos || flag_zero;
            rme_pkg::COND_NZ:     return flag_neg || flag_zero;
            default:              return 1'b0;
        endcase
    endfunction

    // Executes one instruction on the predictor state and returns its result.
    function automatic rme_pkg::t_out execute_instr(input rme_pkg::t_in item);
        rme_pkg::t_out res;
        logic [3:0]  opc;
        logic [5:0]  r1;
        logic [5:0]  r2;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] quot;
        logic [31:0] remd;
        logic [15:0] pc;
        opc = item.instr_word[3:0];
        r1  = item.instr_word[9:4];
        r2  = item.instr_word[15:10];
        a   = arch_regs[r1];
        b   = arch_regs[r2];
        pc  = prog_counter;
        res = '0;
        case (opc)
            rme_pkg::OP_ADD: begin
                arch_regs[r1] = a + b;
                update_flags(arch_regs[r1]);
                pc = pc + 16'd1;
            end
            rme_pkg::OP_SUB: begin
                arch_regs[r1] = a - b;
                update_flags(arch_regs[r1]);
                pc = pc + 16'd1;
            end
            rme_pkg::OP_MUL: begin
                arch_regs[r1] = a * b;
                update_flags(arch_regs[r1]);
                pc = pc + 16'd1;
            end
            rme_pkg::OP_DIV: begin
                if (b == 32'd0) begin
                    res.halted = 1'b1;
                    res.status = rme_pkg::ST_DIV_ZERO;
                end else begin
                    // The most negative value over minus one keeps the dividend.
                    if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
                        quot = a;
                        remd = 32'd0;
                    end else begin
                        quot = $signed(a) / $signed(b);
                        remd = $signed(a) % $signed(b);
                    end
                    arch_regs[r1] = quot;
                    arch_regs[r2] = remd;
                    update_flags(arch_regs[r1]);
                    pc = pc + 16'd1;
                end
            end
            rme_pkg::OP_CMP: begin
                update_flags(a - b);
                pc = pc + 16'd1;
            end
            rme_pkg::OP_MOV: begin
                arch_regs[r1] = b;
                pc = pc + 16'd1;
            end
            rme_pkg::OP_JMP: begin
                if (cond_true(r1)) begin
                    if (!item.immediate[31]) begin
                        pc = pc + item.immediate[15:0] + 16'd2;
                        jump_ldc_count = jump_ldc_count + 16'd1;
                    end else begin
                        pc = pc + item.immediate[15:0] - {jump_ldc_count[14:0], 1'b0};
                        jump_ldc_count = '0;
                    end
                end else begin
                    pc = pc + 16'd3;
                end
            end
            rme_pkg::OP_LDC: begin
                arch_regs[r1] = item.immediate;
                pc = pc + 16'd3;
                jump_ldc_count = jump_ldc_count + 16'd1;
            end
            rme_pkg::OP_INP: begin
                arch_regs[r1] = item.console_value;
                pc = pc + 16'd1;
            end
            rme_pkg::OP_PRT: begin
                res.print_valid = 1'b1;
                res.print_value = a;
                pc = pc + 16'd1;
            end
            rme_pkg::OP_HLT: begin
                pc = 16'hFFFF;
                res.halted = 1'b1;
            end
            default: begin
                res.halted = 1'b1;
                res.status = rme_pkg::ST_BAD_OP;
            end
        endcase
        prog_counter = pc;
        res.next_pc  = pc;
        return res;
    endfunction

    // Predict on each input transfer, compare on each output transfer.
    always @(posedge i_clk) begin
        rme_pkg::t_out want;
        rme_pkg::t_out got;
        if (i_mon_in.valid && i_mon_in.ready) begin
            expected_results.push_back(execute_instr(i_mon_in.payload));
        end
        if (i_mon_out.valid && i_mon_out.ready) begin
            got = i_mon_out.payload;
            if (expected_results.size() == 0) begin
                o_err_count = o_err_count + 1;
                if (o_err_count <= 10)
                    $display("Unexpected result transfer: %p", got);
            end else begin
                want = expected_results.pop_front();
                if (got.next_pc !== want.next_pc || got.print_valid !== want.print_valid ||
                    got.print_value !== want.print_value || got.halted !== want.halted ||
                    got.status !== want.status) begin
                    o_err_count = o_err_count + 1;
                    if (o_err_count <= 10) begin
                        $display("Result mismatch at %0t:", $realtime);
                        $display("  next_pc     exp %h got %h", want.next_pc, got.next_pc);
                        $display("  print_valid exp %b got %b", want.print_valid,
                                 got.print_valid);
                        $display("  print_value exp %h got %h", want.print_value,
                                 got.print_value);
                        $display("  halted      exp %b got %b", want.halted, got.halted);
                        $display("  status      exp %0d got %0d", want.status, got.status);
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end
endmodule
`default_nettype wire

FILE: bench/tb_register_machine_execute_top.sv
`timescale 1ns / 100ps
`default_nettype none
// Drives instructions into the execute block under several idle patterns and
// reports the outcome of the checker.
module tb_register_machine_execute_top;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_ITEMS = 1950;
    localparam int HOLD_CYCLES = 400;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   err_count;
    int   pending;
    int   cycle_count = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_go = 1'b0;
    logic hold_active = 1'b0;

    rme_in_if  in_ch ();
    rme_out_if out_ch ();

    register_machine_execute_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    rme_exec_checker i_checker (
        .i_clk       (i_clk),
        .i_mon_in    (in_ch),
        .i_mon_out   (out_ch),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    always #10 i_clk = ~i_clk;

    // Long hold-off on the result side, counted here once it is requested.
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    // Result side: random stalls, or no ready at all during the hold-off.
    always @(posedge i_clk) begin
        if (hold_active) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic rme_pkg::t_in make_instr(input logic [3:0] opc, input logic [5:0] r1,
                                                input logic [5:0] r2, input logic [31:0] imm,
                                                input logic [31:0] con);
        rme_pkg::t_in item;
        item.instr_word    = {r2, r1, opc};
        item.immediate     = imm;
        item.console_value = con;
        return item;
    endfunction

    // Offers one instruction, with random idle cycles before it, until transfer.
    task automatic send_instr(input rme_pkg::t_in item);
        if ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= item;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    function automatic logic [5:0] pick_reg();
        return ($urandom_range(99) < 75) ? 6'($urandom_range(0, 7)) : 6'($urandom_range(0, 63));
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(0, 20)) - 32'd10;
            default: return $urandom();
        endcase
    endfunction

    // Mostly well-formed instructions on a few registers, some noise and halts.
    function automatic rme_pkg::t_in random_instr();
        logic [3:0]  opc;
        logic [5:0]  r1;
        int          roll;
        roll = $urandom_range(99);
        if (roll < 15) opc = rme_pkg::OP_LDC;
        else if (roll < 22) opc = rme_pkg::OP_INP;
        else if (roll < 26) opc = 4'($urandom_range(10, 15));
        else opc = 4'($urandom_range(0, 9));
        r1 = (opc == rme_pkg::OP_JMP && $urandom_range(9) != 0) ?
             6'($urandom_range(0, 7)) : pick_reg();
        if ($urandom_range(49) == 0)
            return make_instr(4'($urandom()), 6'($urandom()), 6'($urandom()),
                              $urandom(), $urandom());
        return make_instr(opc, r1, pick_reg(), pick_value(), pick_value());
    endfunction

    initial begin
        rme_pkg::t_in directed_list[$];
        int  phase_items;

        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Overflow, divide corner cases, every jump condition and a bad opcode.
        directed_list = '{
            make_instr(rme_pkg::OP_LDC, 6'd1, 6'd0, 32'h7FFF_FFFF, 32'd0),
            make_instr(rme_pkg::OP_LDC, 6'd2, 6'd0, 32'd1, 32'd0),
            make_instr(rme_pkg::OP_ADD, 6'd1, 6'd2, 32'd0, 32'd0),
            make_instr(rme_pkg::OP_LDC, 6'd3, 6'd0, 32'h8000_0000, 32'd0),
            make_instr(rme_pkg::OP_INP, 6'd4, 6'd0, 32'd0, 32'hFFFF_FFFF),
            make_instr(rme_pkg::OP_DIV, 6'd3, 6'd4, 32'd0, 32'd0),
            make_instr(rme_pkg::OP_MUL, 6'd1, 6'd1, 32'd0, 32'd0),
            make_instr(rme_pkg::OP_SUB, 6'd2, 6'd3, 32'd0, 32'd0),
            make_instr(rme_pkg::OP_CMP, 6'd2, 6'd2, 32'd0, 32'd0),
            make_instr(rme_pkg::OP_DIV, 6'd5, 6'd0, 32'd0, 32'd0),
            make_instr(rme_pkg::OP_LDC, 6'd6, 6'd0, 32'hFFFF_FFF9, 32'd0),
            make_instr(rme_pkg::OP_INP, 6'd7, 6'd0, 32'd0, 32'd2),
            make_instr(rme_pkg::OP_DIV, 6'd6, 6'd7, 32'd0, 32'd0),
            make_instr(rme_pkg::OP_DIV, 6'd6, 6'd6, 32'd0, 32'd0),
            make_instr(rme_pkg::OP_MOV, 6'd63, 6'd4, 32'd0, 32'd0),
            make_instr(rme_pkg::OP_JMP, rme_pkg::COND_ALWAYS, 6'd0, 32'h0000_FFFF, 32'd0),
            make_instr(rme_pkg::OP_JMP, rme_pkg::COND_ZERO, 6'd0, 32'd5, 32'd0),
            make_instr(rme_pkg::OP_JMP, rme_pkg::COND_NZERO, 6'd0, 32'd5, 32'd0),
            make_instr(rme_pkg::OP_JMP, rme_pkg::COND_POS, 6'd0, 32'd5, 32'd0),
            make_instr(rme_pkg::OP_JMP, rme_pkg::COND_NEG, 6'd0, 32'hFFFF_FFF0, 32'd0),
            make_instr(rme_pkg::OP_JMP, rme_pkg::COND_PZ, 6'd0, 32'h8000_0000, 32'd0),
            make_instr(rme_pkg::OP_JMP, rme_pkg::COND_NZ, 6'd0, 32'd7, 32'd0),
            make_instr(rme_pkg::OP_JMP, 6'd63, 6'd0, 32'd7, 32'd0),
            make_instr(rme_pkg::OP_PRT, 6'd63, 6'd0, 32'd0, 32'd0),
            make_instr(rme_pkg::OP_HLT, 6'd0, 6'd0, 32'd0, 32'd0),
            make_instr(4'hF, 6'd63, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF)
        };
        foreach (directed_list[i]) send_instr(directed_list[i]);

        // Random phases with different idle patterns on each side.
        phase_items = RANDOM_ITEMS / 4;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            // A long hold-off on the result side fills the block up.
            if (phase == 0) hold_go = 1'b1;
            for (int n = 0; n < phase_items; n++) send_instr(random_instr());
        end
        in_ch.valid <= 1'b0;

        // The checker counts the last transfer at the edge that accepted it.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (err_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire

FILE: register_machine_execute_top.f
rtl/rme_pkg.sv
rtl/rme_if.sv
rtl/rme_muldiv.sv
rtl/register_machine_execute_top.sv
bench/rme_exec_checker.sv
bench/tb_register_machine_execute_top.sv
